>>> rtl/assert_macros.svh
// assertion macros shared by the replacer modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/lpfr_pkg.sv
// lpfr_pkg: sizes, controller/datapath command and status types
// used by lpfr_ctrl, lpfr_dp and lru_page_frame_replacer
package lpfr_pkg;

    localparam int NUM_FRAMES  = 4;
    localparam int PAGE_BITS   = 16;
    localparam int IN_PAGE_W   = 16;
    localparam int IDX_W       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int RANK_W      = IDX_W;
    localparam int FRAME_OUT_W = 2;
    localparam int COUNT_W     = 32;
    localparam logic [RANK_W-1:0] RANK_OLDEST = RANK_W'(NUM_FRAMES - 1);

    typedef struct packed {
        logic load;
        logic lookup;
        logic upd_hit;
        logic upd_fill;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_stat;

endpackage

>>> rtl/lpfr_ctrl.sv
// lpfr_ctrl: sequencer for one request: latch, lookup, update, report
// depends on lpfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lpfr_pkg::t_stat i_stat,
    output lpfr_pkg::t_cmd  o_cmd,
    output logic           busy,
    output logic           o_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_hit  = i_stat.hit;
                o_cmd.upd_fill = !i_stat.hit;
                n_state        = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    `ASSERT_NEXT(a_accept_starts_lookup, i_clk, i_rst_n, start && !busy, o_cmd.lookup)
    `ASSERT_NEXT(a_done_single_cycle, i_clk, i_rst_n, o_done, !o_done && !busy)
    `ASSERT_SAME(a_update_exclusive, i_clk, i_rst_n, 1'b1, !(o_cmd.upd_hit && o_cmd.upd_fill))

endmodule

>>> rtl/lpfr_dp.sv
// lpfr_dp: frame table, parallel tag compare, victim select, rank aging, fault counter
// depends on lpfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module lpfr_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lpfr_pkg::t_cmd                    i_cmd,
    input  logic [lpfr_pkg::IN_PAGE_W-1:0]    i_page_number,
    output lpfr_pkg::t_stat                   o_stat,
    output logic                              o_hit,
    output logic [lpfr_pkg::FRAME_OUT_W-1:0]  o_frame_index,
    output logic [lpfr_pkg::COUNT_W-1:0]      o_fault_count
);

    localparam int N = lpfr_pkg::NUM_FRAMES;

    logic [lpfr_pkg::PAGE_BITS-1:0] r_page;
    logic [lpfr_pkg::PAGE_BITS-1:0] r_res   [N];
    logic [N-1:0]                   r_valid;
    logic [lpfr_pkg::RANK_W-1:0]    r_rank  [N];
    logic [lpfr_pkg::COUNT_W-1:0]   r_faults;
    logic                           r_hit;
    logic [lpfr_pkg::IDX_W-1:0]     r_used;
    logic [lpfr_pkg::RANK_W-1:0]    r_limit;

    logic                           n_hit;
    logic [lpfr_pkg::IDX_W-1:0]     n_used;
    logic [lpfr_pkg::IDX_W-1:0]     hit_idx;
    logic [lpfr_pkg::IDX_W-1:0]     empty_idx;
    logic [lpfr_pkg::IDX_W-1:0]     lru_idx;
    logic                           any_empty;
    logic [lpfr_pkg::RANK_W-1:0]    n_rank  [N];

    // parallel compare and first-match selects
    always_comb begin
        n_hit     = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        lru_idx   = '0;
        any_empty = 1'b0;
        for (int k = N - 1; k >= 0; k--) begin
            if (r_valid[k] && (r_res[k] == r_page)) begin
                n_hit   = 1'b1;
                hit_idx = lpfr_pkg::IDX_W'(k);
            end
            if (!r_valid[k]) begin
                any_empty = 1'b1;
                empty_idx = lpfr_pkg::IDX_W'(k);
            end
            if (r_rank[k] == lpfr_pkg::RANK_OLDEST) begin
                lru_idx = lpfr_pkg::IDX_W'(k);
            end
        end
        if (n_hit) begin
            n_used = hit_idx;
        end else if (any_empty) begin
            n_used = empty_idx;
        end else begin
            n_used = lru_idx;
        end
    end

    // rank aging
    always_comb begin
        for (int k = 0; k < N; k++) begin
            n_rank[k] = r_rank[k];
            if (lpfr_pkg::IDX_W'(k) == r_used) begin
                n_rank[k] = '0;
            end else if (r_valid[k] && (r_rank[k] != lpfr_pkg::RANK_OLDEST)
                         && (i_cmd.upd_fill || (r_rank[k] < r_limit))) begin
                n_rank[k] = r_rank[k] + lpfr_pkg::RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= lpfr_pkg::PAGE_BITS'(i_page_number);
        end
        if (i_cmd.lookup) begin
            r_hit   <= n_hit;
            r_used  <= n_used;
            r_limit <= r_rank[n_used];
        end
        if (i_cmd.upd_fill) begin
            r_res[r_used] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_faults <= '0;
            for (int k = 0; k < N; k++) begin
                r_rank[k] <= '0;
            end
        end else begin
            if (i_cmd.upd_hit || i_cmd.upd_fill) begin
                for (int k = 0; k < N; k++) begin
                    r_rank[k] <= n_rank[k];
                end
            end
            if (i_cmd.upd_fill) begin
                r_valid[r_used] <= 1'b1;
                if (r_faults != '1) begin
                    r_faults <= r_faults + lpfr_pkg::COUNT_W'(1);
                end
            end
        end
    end

    assign o_stat.hit    = r_hit;
    assign o_hit         = r_hit;
    assign o_frame_index = lpfr_pkg::FRAME_OUT_W'(r_used);
    assign o_fault_count = r_faults;

    `ASSERT_NEXT(a_fill_sets_valid, i_clk, i_rst_n, i_cmd.upd_fill, r_valid[r_used])
    `ASSERT_NEXT(a_used_is_newest, i_clk, i_rst_n, i_cmd.upd_hit || i_cmd.upd_fill,
        r_rank[r_used] == '0)
    `ASSERT_NEXT(a_count_only_on_fault, i_clk, i_rst_n, !i_cmd.upd_fill, $stable(r_faults))

endmodule

>>> rtl/lru_page_frame_replacer.sv
// lru_page_frame_replacer: top level, joins controller and datapath
// depends on lpfr_pkg, lpfr_ctrl, lpfr_dp
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      i_page_number
// result    out        o_done one-cycle strobe   o_hit, o_frame_index, o_fault_count
//
// a request passes through these steps before the next request can be accepted:
// latch, tag compare and victim pick, table update, result strobe
// o_done rises after the table update and is taken at the end of its strobe; busy is high meanwhile
// synchronous active-low reset empties all frames and clears the fault count
// results cannot be stalled; each is valid only during its o_done cycle

module lru_page_frame_replacer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic [lpfr_pkg::IN_PAGE_W-1:0]    i_page_number,
    output logic                              busy,
    output logic                              o_done,
    output logic                              o_hit,
    output logic [lpfr_pkg::FRAME_OUT_W-1:0]  o_frame_index,
    output logic [lpfr_pkg::COUNT_W-1:0]      o_fault_count
);

    lpfr_pkg::t_cmd  cmd;
    lpfr_pkg::t_stat stat;

    lpfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    lpfr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_page_number (i_page_number),
        .o_stat        (stat),
        .o_hit         (o_hit),
        .o_frame_index (o_frame_index),
        .o_fault_count (o_fault_count)
    );

endmodule
